>>> src/signed_int_to_decimal_ascii_defines.svh
// Assertion macros shared by the signed integer to decimal text block.
// Included by sitoa_back, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SITOA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sitoa_pkg.sv
// Package for the signed integer to decimal text block: constants, types and helpers.
// Has no dependencies; every other file of the block but the assertion header uses it.
package sitoa_pkg;

   // Default width of the signed input value.
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Width of a result character and the ASCII codes that are emitted.
   localparam int CHAR_WIDTH = 6;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;

   // Width of one decimal digit in the converter.
   localparam int BCD_DIGIT_WIDTH = 4;

   // Back part sequencer states.
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_SIGN,
      BACK_EMIT
   } back_state_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Number of decimal digits of the largest unsigned value of the given width,
   // from floor(width * log10(2)) + 1.
   function automatic int digit_count(input int width);
      return (width * 30103) / 100000 + 1;
   endfunction

endpackage

>>> src/sitoa_if.sv
// Handshake channels of the signed integer to decimal text block.
// Depends on sitoa_pkg for the default value width and character width.
interface sitoa_req_if #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface sitoa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sitoa_pkg::CHAR_WIDTH-1:0]    character;
   logic                                last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

>>> src/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text: an item of VALUE_WIDTH bits yields from one
// character up to the digit count of the width plus a sign, with the last flag set on
// the final character. The back part converts with a shift-and-add-3 converter, which
// takes one magnitude bit a cycle, then steps through every digit position (DIGITS,
// 10 at 32 bits), emitting it or dropping it as a leading zero; a stalled result
// channel holds the minus sign and each emitted digit. A front stage and a two-entry
// queue take new values while the back part is busy.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sitoa_req_if.sink    req_stream,
   sitoa_rsp_if.source  rsp_stream
);
   import sitoa_pkg::*;

   queue_status_type       status;
   logic                   push;
   logic                   push_neg;
   logic [VALUE_WIDTH-1:0] push_mag;
   logic                   pop;
   logic [VALUE_WIDTH:0]   head_data;

   // Front part: accept and classify.
   sitoa_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_stream),
      .status   (status),
      .push     (push),
      .push_neg (push_neg),
      .push_mag (push_mag)
   );

   // Queue of sign and magnitude pairs.
   sitoa_queue #(
      .WIDTH(VALUE_WIDTH + 1),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_neg, push_mag}),
      .pop       (pop),
      .head_data (head_data),
      .status    (status)
   );

   // Back part: convert and emit.
   sitoa_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .head_neg (head_data[VALUE_WIDTH]),
      .head_mag (head_data[VALUE_WIDTH-1:0]),
      .pop      (pop),
      .rsp      (rsp_stream)
   );

endmodule

>>> src/sitoa_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on sitoa_pkg for the status struct.
module sitoa_queue #(
   parameter int WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT + 1,
   parameter int DEPTH = sitoa_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            head_data,
   output sitoa_pkg::queue_status_type status
);
   import sitoa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Status and head of the queue.
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = entry_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   // Pointer and fill count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/sitoa_front.sv
// Front part: accepts input beats, splits off the sign and forms the magnitude.
// Depends on sitoa_pkg and the request channel interface.
module sitoa_front #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   sitoa_req_if.sink                   req,
   input  sitoa_pkg::queue_status_type status,
   output logic                        push,
   output logic                        push_neg,
   output logic [VALUE_WIDTH-1:0]      push_mag
);
   import sitoa_pkg::*;

   logic                   valid_ff, valid_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [VALUE_WIDTH-1:0] raw;
   logic                   accept;

   // The stage takes a new beat when empty or when its item moves into the queue.
   assign push      = valid_ff && !status.full;
   assign req.ready = !valid_ff || !status.full;
   assign accept    = req.valid && req.ready;

   // Classify the value: sign flag and unsigned magnitude of the full width.
   assign raw    = req.value;
   assign neg_in = raw[VALUE_WIDTH-1];
   assign mag_in = neg_in ? (~raw + VALUE_WIDTH'(1)) : raw;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Classified item; payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   assign push_neg = neg_ff;
   assign push_mag = mag_ff;

endmodule

>>> src/sitoa_back.sv
// Back part: converts a magnitude to decimal digits and emits the text one beat at a time.
// Depends on sitoa_pkg, the response channel interface and the assertion macros.
`include "signed_int_to_decimal_ascii_defines.svh"

module sitoa_back #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sitoa_pkg::queue_status_type status,
   input  logic                        head_neg,
   input  logic [VALUE_WIDTH-1:0]      head_mag,
   output logic                        pop,
   sitoa_rsp_if.source                 rsp
);
   import sitoa_pkg::*;

   localparam int DIGITS    = digit_count(VALUE_WIDTH);
   localparam int BCD_W     = DIGITS * BCD_DIGIT_WIDTH;
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int LEFT_W    = $clog2(DIGITS + 1);

   back_state_type               state_ff, state_in;
   logic                         neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]       mag_ff, mag_in;
   logic [BCD_W-1:0]             bcd_ff, bcd_in;
   logic [BCD_W-1:0]             bcd_adj;
   logic [BIT_CNT_W-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [LEFT_W-1:0]            left_ff, left_in;
   logic                         started_ff, started_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]        char_ff, char_in;
   logic                         last_ff, last_in;
   logic [BCD_DIGIT_WIDTH-1:0]   top_digit;
   logic                         out_free;
   logic                         out_load;

   // Output register: a beat may be loaded when the slot is empty or being taken.
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.character = char_ff;
   assign rsp.last      = last_ff;

   // Most significant digit still held in the converter.
   assign top_digit = bcd_ff[BCD_W-1 -: BCD_DIGIT_WIDTH];

   // Shift-and-add-3 correction: every digit of five or more gets three added
   // before the next shift.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] >= BCD_DIGIT_WIDTH'(5)) begin
            bcd_adj[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] =
               bcd_ff[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] + BCD_DIGIT_WIDTH'(3);
         end
      end
   end

   // Sequencer: take an item, convert one magnitude bit per cycle, then send the
   // sign of a negative value and the digits, dropping leading zeros.
   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      left_in    = left_ff;
      started_in = started_ff;
      pop        = 1'b0;
      out_load   = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!status.empty) begin
               pop        = 1'b1;
               neg_in     = head_neg;
               mag_in     = head_mag;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH);
               left_in    = LEFT_W'(DIGITS);
               started_in = 1'b0;
               state_in   = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               state_in = neg_ff ? BACK_SIGN : BACK_EMIT;
            end
         end
         BACK_SIGN: begin
            if (out_free) begin
               out_load = 1'b1;
               char_in  = ASCII_MINUS;
               last_in  = 1'b0;
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (!started_ff && (top_digit == '0) && (left_ff != LEFT_W'(1))) begin
               // Leading zero: drop it without a beat.
               bcd_in  = {bcd_ff[BCD_W-BCD_DIGIT_WIDTH-1:0], BCD_DIGIT_WIDTH'(0)};
               left_in = left_ff - LEFT_W'(1);
            end else if (out_free) begin
               out_load   = 1'b1;
               char_in    = ASCII_ZERO + CHAR_WIDTH'(top_digit);
               last_in    = (left_ff == LEFT_W'(1));
               started_in = 1'b1;
               bcd_in     = {bcd_ff[BCD_W-BCD_DIGIT_WIDTH-1:0], BCD_DIGIT_WIDTH'(0)};
               left_in    = left_ff - LEFT_W'(1);
               if (left_ff == LEFT_W'(1)) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and output payload; no reset needed.
   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      left_ff    <= left_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   // An item leaves the queue only when the sequencer is free.
   `SITOA_ASSERT_IMPLIES(a_pop_only_idle, clock, reset, pop, state_ff == BACK_IDLE, "pop while busy")
   // Taking an item always starts a conversion.
   `SITOA_ASSERT_NEXT(a_pop_starts_convert, clock, reset, pop, state_ff == BACK_CONVERT, "no conversion after pop")
   // The final beat of a number returns the sequencer to idle.
   `SITOA_ASSERT_NEXT(a_last_ends_item, clock, reset, out_load && last_in, state_ff == BACK_IDLE, "busy after last beat")
   // While emitting, at least one digit is still to go.
   `SITOA_ASSERT_IMPLIES(a_emit_has_digits, clock, reset, state_ff == BACK_EMIT, left_ff != '0, "emit with no digits left")
   // A minus sign is never the end of a number.
   `SITOA_ASSERT_IMPLIES(a_minus_not_last, clock, reset, out_load && (char_in == ASCII_MINUS), !last_in, "minus flagged last")

endmodule

>>> bench/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: random and directed values in, checked text out.
// Depends on sitoa_pkg, the sitoa_req_if and sitoa_rsp_if interfaces and the block itself.
module signed_int_to_decimal_ascii_tb;
   import sitoa_pkg::*;

   localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
   localparam int RADIX = 10;
   localparam int RANDOM_VALUES = 107;
   localparam int CALM_TAIL = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_CHARS = 150;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT = 4000;

   // One character of expected decimal text.
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } text_char_type;

   logic clock;
   logic reset = 1'b1;

   // Stimulus-side signals, known from time zero.
   logic                          req_valid = 1'b0;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_ready = 1'b0;

   sitoa_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   sitoa_rsp_if rsp_bus ();

   assign req_bus.valid = req_valid;
   assign req_bus.value = req_value;
   assign rsp_bus.ready = rsp_ready;

   signed_int_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_stream(req_bus),
      .rsp_stream(rsp_bus)
   );

   logic signed [VALUE_WIDTH-1:0] pending_values[$];
   text_char_type                 expected_text[$];

   int values_accepted = 0;
   int negatives_accepted = 0;
   int longest_text = 0;
   int chars_checked = 0;
   int error_count = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the decimal text of one accepted value and queue it as expected.
   function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [3:0]             digits[$];
      text_char_type          text_char;
      magnitude = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      // The most negative value wraps to its own pattern, read here as unsigned.
      do begin
         digits.push_front(4'(magnitude % RADIX));
         magnitude = magnitude / RADIX;
      end while (magnitude != 0);
      if (value[VALUE_WIDTH-1]) begin
         text_char.character = ASCII_MINUS;
         text_char.last = 1'b0;
         expected_text.push_back(text_char);
         negatives_accepted++;
      end
      foreach (digits[i]) begin
         text_char.character = ASCII_ZERO + CHAR_WIDTH'(digits[i]);
         text_char.last = (i == digits.size() - 1);
         expected_text.push_back(text_char);
      end
      if (digits.size() + int'(value[VALUE_WIDTH-1]) > longest_text) begin
         longest_text = digits.size() + int'(value[VALUE_WIDTH-1]);
      end
   endfunction

   // Random value: full range, small numbers, wide spread of lengths, or near a power of ten.
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] raw;
      longint unsigned        scale;
      int unsigned            kind;
      raw = $urandom;
      kind = $urandom_range(0, 3);
      case (kind)
         0: begin
         end
         1: begin
            raw = $urandom_range(0, 99);
         end
         2: begin
            raw = raw >> $urandom_range(0, VALUE_WIDTH - 1);
         end
         default: begin
            scale = 1;
            repeat ($urandom_range(1, 9)) scale = scale * RADIX;
            raw = VALUE_WIDTH'(scale + $urandom_range(0, 2) - 1);
         end
      endcase
      if (kind != 0 && $urandom_range(0, 1) == 1) begin
         raw = ~raw + 1'b1;
      end
      return raw;
   endfunction

   // Sender: offers the head of the pending queue, with random idle bursts.
   int send_gap = 0;
   always @(posedge clock) begin
      logic next_valid;
      logic quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_bus.ready) begin
            predict_text(req_value);
            values_accepted++;
            void'(pending_values.pop_front());
            next_valid = 1'b0;
         end
         // Every third block of twenty values and the tail of the run go without gaps.
         quiet = (pending_values.size() <= CALM_TAIL) || ((values_accepted / 20) % 3 == 2);
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_values.size() != 0) begin
               if (!quiet && $urandom_range(0, 3) == 0) begin
                  send_gap = $urandom_range(1, 6) - 1;
               end else begin
                  next_valid = 1'b1;
                  req_value <= pending_values[0];
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: checks each character beat and applies stalls and one long hold-off.
   int stall_left = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      text_char_type wanted;
      logic          quiet;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               $error("unexpected character beat: character %0d, last %0d",
                      rsp_bus.character, rsp_bus.last);
               error_count++;
            end else begin
               wanted = expected_text.pop_front();
               if (rsp_bus.character !== wanted.character) begin
                  $error("character: expected %0d, actual %0d",
                         wanted.character, rsp_bus.character);
                  error_count++;
               end
               if (rsp_bus.last !== wanted.last) begin
                  $error("last: expected %0d, actual %0d", wanted.last, rsp_bus.last);
                  error_count++;
               end
            end
         end
         // The long hold-off lets the block fill up and push back on the sender.
         if (!hold_done && chars_checked >= HOLD_AFTER_CHARS) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         quiet = (pending_values.size() <= CALM_TAIL) || ((chars_checked / 60) % 3 == 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat for %0d cycles.", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic signed [VALUE_WIDTH-1:0] directed[$];
      directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                   999999999, 1000000000, -1000000000, 123456789, -987654321,
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh8000_0001, 32'sh7FFF_FFFE};
      foreach (directed[i]) pending_values.push_back(directed[i]);
      repeat (RANDOM_VALUES) pending_values.push_back(random_value());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_valid || expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_text.size() != 0) begin
         $error("%0d expected characters never arrived", expected_text.size());
         error_count++;
      end
      $display("Converted %0d values (%0d negative) into %0d characters.",
               values_accepted, negatives_accepted, chars_checked);
      $display("Longest text was %0d characters; one long result hold-off was applied.",
               longest_text);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
